[src/mbx_ep_pkg.sv]
// ---------------------------------------------------------------------------
// mbx_ep_pkg: shared types and codes for the mailbox endpoint table
// Operation kinds, endpoint states, status codes and controller commands.
// ---------------------------------------------------------------------------
`default_nettype none
package mbx_ep_pkg;

	localparam logic [2:0] KIND_CREATE  = 3'd0;
	localparam logic [2:0] KIND_SEND    = 3'd1;
	localparam logic [2:0] KIND_RECV    = 3'd2;
	localparam logic [2:0] KIND_TRYRECV = 3'd3;
	localparam logic [2:0] KIND_NOTIFY  = 3'd4;

	// stored state of a claimed endpoint; free is implied by the claim count
	localparam logic [1:0] ST_IDLE      = 2'd1;
	localparam logic [1:0] ST_SEND_WAIT = 2'd2;
	localparam logic [1:0] ST_RECV_WAIT = 2'd3;

	localparam logic [1:0] RES_OK    = 2'd0;
	localparam logic [1:0] RES_ERR   = 2'd1;
	localparam logic [1:0] RES_BLOCK = 2'd2;

	localparam logic [15:0] ID_NONE = 16'hFFFF;

	typedef struct packed {
		logic capture;
		logic exec;
	} mbx_cmd_t;

endpackage
`default_nettype wire

[src/mailbox_endpoint_table.sv]
// Sequence: a word is captured along with its memory read, then its result is loaded
// into the output register on execute, which waits while an untaken result holds it.
// Operations run one at a time (capture plus memory read, then execute and write
// back), set by the single read-modify-write port of the endpoint memories.
// Reset: all endpoints free at once through the claim counter; no clearing pass.
// ---------------------------------------------------------------------------
// mailbox_endpoint_table: mailbox endpoint table with doorbells
// Create, send, receive, try-receive and notify on a table of endpoints.
// ---------------------------------------------------------------------------
`default_nettype none
module mailbox_endpoint_table
	import mbx_ep_pkg::*;
#(
	parameter int ENDPOINT_COUNT = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic        [2:0]  kind,
	input  wire logic        [5:0]  endpoint,
	input  wire logic        [14:0] owner_process,
	input  wire logic signed [15:0] caller_process,
	input  wire logic        [14:0] caller_thread,
	input  wire logic        [63:0] word0_in,
	input  wire logic        [63:0] word1_in,
	input  wire logic        [63:0] word2_in,
	input  wire logic        [63:0] word3_in,
	input  wire logic signed [15:0] message_sender,
	input  wire logic        [63:0] doorbell_bits,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [1:0]  status,
	output logic             [5:0]  new_endpoint,
	output logic                    message_valid,
	output logic             [63:0] word0_out,
	output logic             [63:0] word1_out,
	output logic             [63:0] word2_out,
	output logic             [63:0] word3_out,
	output logic signed      [15:0] delivered_sender,
	output logic                    wake_valid,
	output logic             [14:0] wake_thread
);

	mbx_cmd_t cmd;

	// sequencer
	mbx_ep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// table and result datapath; owner and caller process ids are not read back
	mbx_ep_dp #(
		.ENDPOINT_COUNT (ENDPOINT_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.kind             (kind),
		.endpoint         (endpoint),
		.caller_thread    (caller_thread),
		.word0_in         (word0_in),
		.word1_in         (word1_in),
		.word2_in         (word2_in),
		.word3_in         (word3_in),
		.message_sender   (message_sender),
		.doorbell_bits    (doorbell_bits),
		.status           (status),
		.new_endpoint     (new_endpoint),
		.message_valid    (message_valid),
		.word0_out        (word0_out),
		.word1_out        (word1_out),
		.word2_out        (word2_out),
		.word3_out        (word3_out),
		.delivered_sender (delivered_sender),
		.wake_valid       (wake_valid),
		.wake_thread      (wake_thread)
	);

endmodule
`default_nettype wire

[src/mbx_ep_ctrl.sv]
// ---------------------------------------------------------------------------
// mbx_ep_ctrl: operation sequencer
// Takes a word, runs the execute cycle once the result register is free,
// and tracks the result register's valid flag.
// ---------------------------------------------------------------------------
`default_nettype none
module mbx_ep_ctrl
	import mbx_ep_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output mbx_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free      = !out_valid_q || out_ready;
	assign in_ready      = (state_q == S_IDLE);
	assign cmd.capture   = in_valid && in_ready;
	assign cmd.exec      = (state_q == S_EXEC) && out_free;
	assign out_valid     = out_valid_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.exec) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

[src/mbx_ep_dp.sv]
// ---------------------------------------------------------------------------
// mbx_ep_dp: endpoint table datapath
// Endpoint memories, claim counter, operation decode and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module mbx_ep_dp
	import mbx_ep_pkg::*;
#(
	parameter int ENDPOINT_COUNT = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mbx_cmd_t           cmd,
	input  wire logic        [2:0]  kind,
	input  wire logic        [5:0]  endpoint,
	input  wire logic        [14:0] caller_thread,
	input  wire logic        [63:0] word0_in,
	input  wire logic        [63:0] word1_in,
	input  wire logic        [63:0] word2_in,
	input  wire logic        [63:0] word3_in,
	input  wire logic signed [15:0] message_sender,
	input  wire logic        [63:0] doorbell_bits,
	output logic             [1:0]  status,
	output logic             [5:0]  new_endpoint,
	output logic                    message_valid,
	output logic             [63:0] word0_out,
	output logic             [63:0] word1_out,
	output logic             [63:0] word2_out,
	output logic             [63:0] word3_out,
	output logic signed      [15:0] delivered_sender,
	output logic                    wake_valid,
	output logic             [14:0] wake_thread
);

	localparam int AW = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
	localparam int CW = $clog2(ENDPOINT_COUNT + 1);
	localparam int XW = (AW > 6) ? AW : 6;
	localparam logic [CW-1:0] COUNT_MAX = CW'(ENDPOINT_COUNT);

	// captured operation
	logic [2:0]   kind_q;
	logic [XW-1:0] ep_q;
	logic [14:0]  cthr_q;
	logic [255:0] msg_in_q;
	logic [15:0]  sender_q;
	logic [63:0]  bits_q;

	// claim counter: endpoints are claimed in index order and never released
	logic [CW-1:0] count_q;

	// memory read data
	logic [1:0]   st_rd_q;
	logic [15:0]  thr_rd_q;
	logic [63:0]  db_rd_q;
	logic [255:0] msg_rd_q;
	logic [15:0]  org_rd_q;

	logic [1:0]   st_mem  [ENDPOINT_COUNT];
	logic [15:0]  thr_mem [ENDPOINT_COUNT];
	logic [63:0]  db_mem  [ENDPOINT_COUNT];
	logic [255:0] msg_mem [ENDPOINT_COUNT];
	logic [15:0]  org_mem [ENDPOINT_COUNT];

	logic [XW-1:0] ep_in_x;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	// execute decode
	logic        st_we, thr_we, db_we, msg_we;
	logic [1:0]  st_wd;
	logic [15:0] thr_wd;
	logic [63:0] db_wd;
	logic        count_inc;
	logic [1:0]  status_d;
	logic [5:0]  new_ep_d;
	logic        msg_v_d;
	logic [255:0] msg_out_d;
	logic [15:0] dsender_d;
	logic        wake_v_d;
	logic [14:0] wake_thr_d;
	logic        ep_bad;
	logic        thr_live;

	assign ep_in_x = XW'(endpoint);
	assign rd_addr = ep_in_x[AW-1:0];

	// capture the word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			ep_q     <= ep_in_x;
			cthr_q   <= caller_thread;
			msg_in_q <= {word3_in, word2_in, word1_in, word0_in};
			sender_q <= message_sender;
			bits_q   <= doorbell_bits;
		end
	end

	// claim counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (count_inc) begin
			count_q <= count_q + CW'(1);
		end
	end

	// endpoint memories
	always_ff @(posedge clk) begin
		if (st_we) st_mem[wr_addr] <= st_wd;
		if (cmd.capture) st_rd_q <= st_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (thr_we) thr_mem[wr_addr] <= thr_wd;
		if (cmd.capture) thr_rd_q <= thr_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (db_we) db_mem[wr_addr] <= db_wd;
		if (cmd.capture) db_rd_q <= db_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (msg_we) msg_mem[wr_addr] <= msg_in_q;
		if (cmd.capture) msg_rd_q <= msg_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (msg_we) org_mem[wr_addr] <= sender_q;
		if (cmd.capture) org_rd_q <= org_mem[rd_addr];
	end

	assign ep_bad   = (kind_q > KIND_NOTIFY) || ({1'b0, ep_q} >= (XW+1)'(ENDPOINT_COUNT)) ||
		({1'b0, ep_q} >= (XW+1)'(count_q));
	assign thr_live = !thr_rd_q[15] && (thr_rd_q != 16'd0);

	// operation decode
	always_comb begin
		st_we      = 1'b0;
		thr_we     = 1'b0;
		db_we      = 1'b0;
		msg_we     = 1'b0;
		st_wd      = ST_IDLE;
		thr_wd     = ID_NONE;
		db_wd      = '0;
		count_inc  = 1'b0;
		wr_addr    = ep_q[AW-1:0];
		status_d   = RES_ERR;
		new_ep_d   = '0;
		msg_v_d    = 1'b0;
		msg_out_d  = '0;
		dsender_d  = '0;
		wake_v_d   = 1'b0;
		wake_thr_d = '0;
		if (kind_q == KIND_CREATE) begin
			wr_addr = count_q[AW-1:0];
			if (count_q < COUNT_MAX) begin
				st_we     = 1'b1;
				thr_we    = 1'b1;
				db_we     = 1'b1;
				count_inc = 1'b1;
				status_d  = RES_OK;
				new_ep_d  = 6'(count_q);
			end
		end else if (!ep_bad) begin
			case (kind_q)
				KIND_SEND: begin
					msg_we   = 1'b1;
					st_we    = 1'b1;
					status_d = RES_OK;
					if (st_rd_q == ST_RECV_WAIT) begin
						st_wd = ST_IDLE;
						if (thr_live) begin
							wake_v_d   = 1'b1;
							wake_thr_d = thr_rd_q[14:0];
							thr_we     = 1'b1;
						end
					end else begin
						st_wd = ST_SEND_WAIT;
					end
				end
				KIND_RECV, KIND_TRYRECV: begin
					if (db_rd_q != 64'd0) begin
						db_we     = 1'b1;
						msg_v_d   = 1'b1;
						msg_out_d = {192'd0, db_rd_q};
						dsender_d = ID_NONE;
						status_d  = RES_OK;
					end else if (st_rd_q == ST_SEND_WAIT) begin
						st_we     = 1'b1;
						st_wd     = ST_IDLE;
						msg_v_d   = 1'b1;
						msg_out_d = msg_rd_q;
						dsender_d = org_rd_q;
						status_d  = RES_OK;
					end else if (kind_q == KIND_RECV) begin
						st_we    = 1'b1;
						st_wd    = ST_RECV_WAIT;
						status_d = RES_BLOCK;
						if (cthr_q != 15'd0) begin
							thr_we = 1'b1;
							thr_wd = {1'b0, cthr_q};
						end
					end
				end
				KIND_NOTIFY: begin
					db_we    = 1'b1;
					db_wd    = db_rd_q | bits_q;
					status_d = RES_OK;
					if (st_rd_q == ST_RECV_WAIT) begin
						st_we = 1'b1;
						st_wd = ST_IDLE;
						if (thr_live) begin
							wake_v_d   = 1'b1;
							wake_thr_d = thr_rd_q[14:0];
							thr_we     = 1'b1;
						end
					end
				end
				default: status_d = RES_ERR;
			endcase
		end
		if (!cmd.exec) begin
			st_we     = 1'b0;
			thr_we    = 1'b0;
			db_we     = 1'b0;
			msg_we    = 1'b0;
			count_inc = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status           <= status_d;
			new_endpoint     <= new_ep_d;
			message_valid    <= msg_v_d;
			word0_out        <= msg_out_d[63:0];
			word1_out        <= msg_out_d[127:64];
			word2_out        <= msg_out_d[191:128];
			word3_out        <= msg_out_d[255:192];
			delivered_sender <= dsender_d;
			wake_valid       <= wake_v_d;
			wake_thread      <= wake_thr_d;
		end
	end

endmodule
`default_nettype wire

[verif/mailbox_endpoint_table_checker.sv]
// ---------------------------------------------------------------------------
// mailbox_endpoint_table_checker: result checker for the endpoint table
// Watches both channels, keeps its own copy of the endpoint table, predicts
// each result word and compares it field by field in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none
module mailbox_endpoint_table_checker
	import mbx_ep_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic        [2:0]  kind,
	input  wire logic        [5:0]  endpoint,
	input  wire logic signed [15:0] caller_process,
	input  wire logic        [14:0] caller_thread,
	input  wire logic        [63:0] word0_in,
	input  wire logic        [63:0] word1_in,
	input  wire logic        [63:0] word2_in,
	input  wire logic        [63:0] word3_in,
	input  wire logic signed [15:0] message_sender,
	input  wire logic        [63:0] doorbell_bits,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic        [1:0]  status,
	input  wire logic        [5:0]  new_endpoint,
	input  wire logic               message_valid,
	input  wire logic        [63:0] word0_out,
	input  wire logic        [63:0] word1_out,
	input  wire logic        [63:0] word2_out,
	input  wire logic        [63:0] word3_out,
	input  wire logic signed [15:0] delivered_sender,
	input  wire logic               wake_valid,
	input  wire logic        [14:0] wake_thread,
	output int                      fail_count,
	output int                      pending_count,
	output int                      reply_count
);

	localparam int EP_COUNT = 64;
	localparam logic [1:0] ST_FREE = 2'd0;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  new_ep;
		logic        msg_valid;
		logic [63:0] w0, w1, w2, w3;
		logic [15:0] sender;
		logic        wake;
		logic [14:0] wake_thr;
	} reply_t;

	// shadow endpoint table
	logic [1:0]  ep_state  [EP_COUNT];
	logic [15:0] blk_proc  [EP_COUNT];
	logic [15:0] blk_thr   [EP_COUNT];
	logic [63:0] bell      [EP_COUNT];
	logic [63:0] mail      [EP_COUNT][4];
	logic [15:0] mail_from [EP_COUNT];

	reply_t expected_replies[$];

	// wake the recorded receiver and clear the blocked ids
	function automatic void wake_receiver(input int e, inout reply_t r);
		if (!blk_thr[e][15] && blk_thr[e] != 16'd0) begin
			r.wake = 1'b1;
			r.wake_thr = blk_thr[e][14:0];
			blk_thr[e] = ID_NONE;
		end
		blk_proc[e] = ID_NONE;
	endfunction

	function automatic reply_t predict_reply();
		reply_t r;
		int e;
		r = '0;
		r.status = RES_ERR;
		if (kind == KIND_CREATE) begin
			for (e = 0; e < EP_COUNT; e++) begin
				if (ep_state[e] == ST_FREE) begin
					ep_state[e] = ST_IDLE;
					blk_proc[e] = ID_NONE;
					blk_thr[e] = ID_NONE;
					bell[e] = '0;
					r.status = RES_OK;
					r.new_ep = e[5:0];
					break;
				end
			end
			return r;
		end
		e = endpoint;
		if (kind > KIND_NOTIFY || ep_state[e] == ST_FREE)
			return r;
		case (kind)
			KIND_SEND: begin
				mail[e][0] = word0_in;
				mail[e][1] = word1_in;
				mail[e][2] = word2_in;
				mail[e][3] = word3_in;
				mail_from[e] = message_sender;
				if (ep_state[e] == ST_RECV_WAIT) begin
					ep_state[e] = ST_IDLE;
					wake_receiver(e, r);
				end else begin
					ep_state[e] = ST_SEND_WAIT;
					if (caller_process != ID_NONE)
						blk_proc[e] = caller_process;
				end
				r.status = RES_OK;
			end
			KIND_RECV, KIND_TRYRECV: begin
				if (bell[e] != '0) begin
					r.msg_valid = 1'b1;
					r.w0 = bell[e];
					r.sender = ID_NONE;
					bell[e] = '0;
					r.status = RES_OK;
				end else if (ep_state[e] == ST_SEND_WAIT) begin
					r.msg_valid = 1'b1;
					r.w0 = mail[e][0];
					r.w1 = mail[e][1];
					r.w2 = mail[e][2];
					r.w3 = mail[e][3];
					r.sender = mail_from[e];
					ep_state[e] = ST_IDLE;
					blk_proc[e] = ID_NONE;
					r.status = RES_OK;
				end else if (kind == KIND_RECV) begin
					ep_state[e] = ST_RECV_WAIT;
					if (caller_process != ID_NONE)
						blk_proc[e] = caller_process;
					if (caller_thread != '0)
						blk_thr[e] = {1'b0, caller_thread};
					r.status = RES_BLOCK;
				end
			end
			default: begin
				bell[e] |= doorbell_bits;
				if (ep_state[e] == ST_RECV_WAIT) begin
					ep_state[e] = ST_IDLE;
					wake_receiver(e, r);
				end
				r.status = RES_OK;
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, actual %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	assign pending_count = expected_replies.size();

	// predict on each accepted word, compare each returned word
	always @(posedge clk or negedge arst_n) begin
		reply_t r;
		if (!arst_n) begin
			for (int i = 0; i < EP_COUNT; i++) begin
				ep_state[i] = ST_FREE;
				blk_proc[i] = ID_NONE;
				blk_thr[i] = ID_NONE;
				bell[i] = '0;
			end
			expected_replies.delete();
			fail_count = 0;
			reply_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				reply_count++;
				if (expected_replies.size() == 0) begin
					$error("result word with no operation outstanding");
					fail_count++;
				end else begin
					r = expected_replies.pop_front();
					compare_field("status", 64'(r.status), 64'(status));
					compare_field("new_endpoint", 64'(r.new_ep), 64'(new_endpoint));
					compare_field("message_valid", 64'(r.msg_valid), 64'(message_valid));
					compare_field("word0_out", r.w0, word0_out);
					compare_field("word1_out", r.w1, word1_out);
					compare_field("word2_out", r.w2, word2_out);
					compare_field("word3_out", r.w3, word3_out);
					compare_field("delivered_sender", 64'(r.sender),
						64'($unsigned(delivered_sender)));
					compare_field("wake_valid", 64'(r.wake), 64'(wake_valid));
					compare_field("wake_thread", 64'(r.wake_thr), 64'(wake_thread));
				end
			end
			if (in_valid && in_ready)
				expected_replies.push_back(predict_reply());
		end
	end

endmodule
`default_nettype wire

[verif/mailbox_endpoint_table_test.sv]
// ---------------------------------------------------------------------------
// mailbox_endpoint_table_test: testbench top for the endpoint table
// Drives directed and random operations with random idling on both sides
// and reports the checker's verdict.
// ---------------------------------------------------------------------------
`default_nettype none
module mailbox_endpoint_table_test;
	import mbx_ep_pkg::*;

	localparam int RANDOM_OPS = 520;
	localparam int QUIET_LIMIT = 2000;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0]  kind;
	logic [5:0]  endpoint;
	logic [14:0] owner_process;
	logic signed [15:0] caller_process;
	logic [14:0] caller_thread;
	logic [63:0] word0_in, word1_in, word2_in, word3_in;
	logic signed [15:0] message_sender;
	logic [63:0] doorbell_bits;
	logic [1:0]  status;
	logic [5:0]  new_endpoint;
	logic        message_valid;
	logic [63:0] word0_out, word1_out, word2_out, word3_out;
	logic signed [15:0] delivered_sender;
	logic        wake_valid;
	logic [14:0] wake_thread;
	int fail_count, pending_count, reply_count;
	int quiet_cycles;
	int ops_sent;
	bit drain_phase;
	bit stim_done;

	// number of endpoints claimed so far
	int claimed;

	mailbox_endpoint_table u_top (.*);

	mailbox_endpoint_table_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random sink stalls in bursts, none in the drain phase
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			out_ready <= 1'b1;
			n = $urandom_range(1, 30);
			repeat (n) @(posedge clk);
			if (!drain_phase && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 19);
				repeat (n) @(posedge clk);
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT && !stim_done) begin
				$display("** mailbox_endpoint_table: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_op(input logic [2:0] k, input logic [5:0] ep,
		input logic [63:0] bits);
		kind <= k;
		endpoint <= ep;
		owner_process <= 15'($urandom);
		caller_process <= ($urandom_range(0, 5) == 0) ? ID_NONE : 16'($urandom);
		caller_thread <= ($urandom_range(0, 5) == 0) ? 15'd0 : 15'($urandom);
		word0_in <= {$urandom, $urandom};
		word1_in <= {$urandom, $urandom};
		word2_in <= {$urandom, $urandom};
		word3_in <= {$urandom, $urandom};
		message_sender <= ($urandom_range(0, 7) == 0) ? ID_NONE : 16'($urandom);
		doorbell_bits <= bits;
		in_valid <= 1'b1;
		@(posedge clk iff in_ready);
		ops_sent++;
		// sender idles in bursts
		if (!drain_phase && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// pick an endpoint, mostly a claimed one
	function automatic logic [5:0] pick_ep();
		return (claimed > 0 && $urandom_range(0, 9) != 0) ?
			6'($urandom_range(0, claimed - 1)) : 6'($urandom);
	endfunction

	initial begin
		logic [2:0] k;
		logic [5:0] ep;
		logic [63:0] bits;
		int roll;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_CREATE;
		endpoint = '0;
		owner_process = '0;
		caller_process = ID_NONE;
		caller_thread = '0;
		word0_in = '0;
		word1_in = '0;
		word2_in = '0;
		word3_in = '0;
		message_sender = ID_NONE;
		doorbell_bits = '0;
		ops_sent = 0;
		drain_phase = 1'b0;
		stim_done = 1'b0;
		claimed = 0;
		repeat (6) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: ops on free endpoints, unknown kinds, traffic on endpoint 0, then a full table
		send_op(KIND_NOTIFY, 6'd0, '1);
		send_op(KIND_TRYRECV, 6'd63, '0);
		send_op(3'd5, 6'd0, '0);
		send_op(3'd7, 6'd63, '0);
		send_op(KIND_CREATE, 6'd0, '0);
		claimed = 1;
		send_op(KIND_TRYRECV, 6'd0, '0);
		send_op(KIND_RECV, 6'd0, '0);
		send_op(KIND_SEND, 6'd0, '0);
		send_op(KIND_RECV, 6'd0, '0);
		send_op(KIND_NOTIFY, 6'd0, 64'h8000_0000_0000_0001);
		send_op(KIND_NOTIFY, 6'd0, '1);
		send_op(KIND_RECV, 6'd0, '0);
		send_op(KIND_SEND, 6'd0, '0);
		send_op(KIND_SEND, 6'd0, '0);
		send_op(KIND_TRYRECV, 6'd0, '0);
		for (int i = 1; i < 64; i++) begin
			send_op(KIND_CREATE, 6'($urandom), '0);
			claimed++;
		end
		send_op(KIND_CREATE, 6'd0, '0);

		// random: mostly valid traffic on claimed endpoints
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i > RANDOM_OPS - 80)
				drain_phase = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 30) k = KIND_SEND;
			else if (roll < 55) k = KIND_RECV;
			else if (roll < 70) k = KIND_TRYRECV;
			else if (roll < 90) k = KIND_NOTIFY;
			else if (roll < 95) k = KIND_CREATE;
			else k = 3'($urandom_range(5, 7));
			ep = pick_ep();
			bits = ($urandom_range(0, 3) == 0) ? '0 :
				(64'd1 << $urandom_range(0, 63)) | {$urandom, $urandom};
			send_op(k, ep, bits);
		end
		in_valid <= 1'b0;
		drain_phase = 1'b1;

		wait (pending_count == 0);
		repeat (10) @(posedge clk);
		stim_done = 1'b1;
		$display("ran %0d operations over all 64 endpoints, %0d results checked",
			ops_sent, reply_count);
		$display("covered create, send, receive, try-receive, notify and bad kinds");
		if (fail_count == 0 && pending_count == 0)
			$display("** mailbox_endpoint_table: PASSED **");
		else
			$display("** mailbox_endpoint_table: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
src/mbx_ep_pkg.sv
src/mbx_ep_ctrl.sv
src/mbx_ep_dp.sv
src/mailbox_endpoint_table.sv
verif/mailbox_endpoint_table_checker.sv
verif/mailbox_endpoint_table_test.sv
